### rtl/nearest_palette_color_search_macros.svh
// Assertion helpers used by npc_ctrl. Each expects i_clk and i_rst_n in scope.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

// Same-cycle implication.
`define NPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/npc_pkg.sv
package npc_pkg;

    localparam int PALETTE_SIZE = 256;
    localparam int IDX_W        = $clog2(PALETTE_SIZE);

    localparam int ACTION_W = 1;
    localparam int ENTRY_W  = 8;
    localparam int COLOR_W  = 8;
    localparam int OUT_IDX_W = 8;
    localparam int SQ_W     = 2 * COLOR_W;
    localparam int DIST_W   = 23;

    localparam logic [ACTION_W-1:0] ACT_LOAD     = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_QUANTIZE = 1'b1;

    localparam logic [DIST_W-1:0] W_RED   = 23'd28;
    localparam logic [DIST_W-1:0] W_GREEN = 23'd91;
    localparam logic [DIST_W-1:0] W_BLUE  = 23'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_npc_state;

    typedef struct packed {
        logic             load_we;
        logic             capture;
        logic             issue;
        logic             first;
        logic             push;
        logic [IDX_W-1:0] addr;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
    } t_dp_sts;

endpackage

### rtl/npc_if.sv
interface npc_in_if import npc_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ENTRY_W-1:0]  entry_index;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;

    modport source (output valid, action, entry_index, red, green, blue, input ready);
    modport sink   (input valid, action, entry_index, red, green, blue, output ready);
endinterface

interface npc_out_if import npc_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] nearest_index;
    logic [DIST_W-1:0]    best_distance;

    modport source (output valid, nearest_index, best_distance, input ready);
    modport sink   (input valid, nearest_index, best_distance, output ready);
endinterface

### rtl/npc_datapath.sv
module npc_datapath import npc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [ENTRY_W-1:0]   i_entry_index,
    input  logic [COLOR_W-1:0]   i_red,
    input  logic [COLOR_W-1:0]   i_green,
    input  logic [COLOR_W-1:0]   i_blue,
    output t_dp_sts              o_sts,
    output logic [OUT_IDX_W-1:0] o_nearest_index,
    output logic [DIST_W-1:0]    o_best_distance
);

    logic [3*COLOR_W-1:0] mem [PALETTE_SIZE];
    logic [PALETTE_SIZE-1:0] r_vld;

    logic [COLOR_W-1:0] r_px_r, r_px_g, r_px_b;

    // read stage
    logic [3*COLOR_W-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic                 r_s0_v, r_s0_first;
    logic [IDX_W-1:0]     r_s0_idx;

    // square stage
    logic [SQ_W-1:0]  r_sq_r, r_sq_g, r_sq_b;
    logic             r_s1_v, r_s1_first;
    logic [IDX_W-1:0] r_s1_idx;

    // weighted-sum stage
    logic [DIST_W-1:0] r_dist;
    logic              r_s2_v, r_s2_first;
    logic [IDX_W-1:0]  r_s2_idx;

    logic [DIST_W-1:0] r_best;
    logic [IDX_W-1:0]  r_best_idx;

    logic [3*COLOR_W-1:0] entry;
    logic [COLOR_W-1:0]   d_r, d_g, d_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            mem[i_entry_index[IDX_W-1:0]] <= {i_red, i_green, i_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.load_we) begin
            r_vld[i_entry_index[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s0_v <= i_cmd.issue;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
        end
    end

    // unwritten entries read as black
    assign entry = r_rd_vld ? r_rd_data : '0;

    always_comb begin
        d_r = (r_px_r > entry[3*COLOR_W-1:2*COLOR_W]) ?
              r_px_r - entry[3*COLOR_W-1:2*COLOR_W] : entry[3*COLOR_W-1:2*COLOR_W] - r_px_r;
        d_g = (r_px_g > entry[2*COLOR_W-1:COLOR_W]) ?
              r_px_g - entry[2*COLOR_W-1:COLOR_W] : entry[2*COLOR_W-1:COLOR_W] - r_px_g;
        d_b = (r_px_b > entry[COLOR_W-1:0]) ?
              r_px_b - entry[COLOR_W-1:0] : entry[COLOR_W-1:0] - r_px_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px_r <= i_red;
            r_px_g <= i_green;
            r_px_b <= i_blue;
        end
        r_rd_vld   <= r_vld[i_cmd.addr];
        r_s0_first <= i_cmd.first;
        r_s0_idx   <= i_cmd.addr;

        r_sq_r     <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g     <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b     <= SQ_W'(d_b) * SQ_W'(d_b);
        r_s1_first <= r_s0_first;
        r_s1_idx   <= r_s0_idx;

        r_dist     <= W_RED * DIST_W'(r_sq_r) + W_GREEN * DIST_W'(r_sq_g)
                    + W_BLUE * DIST_W'(r_sq_b);
        r_s2_first <= r_s1_first;
        r_s2_idx   <= r_s1_idx;

        // strict less-than keeps the lowest index on a tie
        if (r_s2_v && (r_s2_first || (r_dist < r_best))) begin
            r_best     <= r_dist;
            r_best_idx <= r_s2_idx;
        end

        if (i_cmd.push) begin
            o_nearest_index <= OUT_IDX_W'(r_best_idx);
            o_best_distance <= r_best;
        end
    end

    assign o_sts.busy = r_s0_v | r_s1_v | r_s2_v;

endmodule

### rtl/npc_ctrl.sv
`include "nearest_palette_color_search_macros.svh"

module npc_ctrl import npc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [ACTION_W-1:0] i_in_action,
    input  logic [ENTRY_W-1:0]  i_in_entry_index,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    input  t_dp_sts             i_sts,
    output t_dp_cmd             o_cmd
);

    t_npc_state       r_state, n_state;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic             r_out_valid, n_out_valid;
    logic             in_range;
    logic             addr_last;

    assign in_range  = {1'b0, i_in_entry_index} < (ENTRY_W + 1)'(PALETTE_SIZE);
    assign addr_last = r_addr == IDX_W'(PALETTE_SIZE - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.addr  = r_addr;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_action == ACT_QUANTIZE) begin
                        o_cmd.capture = 1'b1;
                        n_addr        = '0;
                        n_state       = ST_SCAN;
                    end else begin
                        // drop loads beyond the palette
                        o_cmd.load_we = in_range;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                o_cmd.first = r_addr == '0;
                if (addr_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy && (!r_out_valid || i_out_ready)) begin
                    o_cmd.push  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `NPC_ASSERT_NEXT(a_scan_start, i_in_valid && o_in_ready && i_in_action == ACT_QUANTIZE, r_state == ST_SCAN && r_addr == '0, "scan did not start at entry zero")
    `NPC_ASSERT_NEXT(a_scan_end, r_state == ST_SCAN && addr_last, r_state == ST_DRAIN, "scan did not end after last entry")
    `NPC_ASSERT_NEXT(a_push_out, o_cmd.push, r_out_valid && r_state == ST_IDLE, "result push lost")
    `NPC_ASSERT_NOW(a_push_idle_pipe, r_state == ST_DRAIN && !i_sts.busy && !r_out_valid, o_cmd.push, "drained scan not pushed")

endmodule

### rtl/nearest_palette_color_search.sv
// Channel  Dir  Modport  Payload
// i_pix    in   sink     action, entry_index, red, green, blue
// o_res    out  source   nearest_index, best_distance
//
// A load transaction writes one palette entry.
// A quantize transaction reads one palette entry per cycle from the single memory read port,
// then the read / square / weighted-sum / compare pipeline drains and the result is pushed to
// the output register; the next transaction can be taken in the same cycle the result turns valid.
// Reset clears the per-entry valid bits at once; unwritten entries read as black.
// The result waits in an output register while new transactions are taken; a finished scan
// holds in the drain state until that register is free.
module nearest_palette_color_search import npc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    npc_in_if.sink   i_pix,
    npc_out_if.source o_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // controller: scan sequencing and result handshake
    npc_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_pix.valid),
        .i_in_action      (i_pix.action),
        .i_in_entry_index (i_pix.entry_index),
        .o_in_ready       (i_pix.ready),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .i_sts            (sts),
        .o_cmd            (cmd)
    );

    // datapath: palette memory, distance pipeline, best tracker, output register
    npc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_entry_index   (i_pix.entry_index),
        .i_red           (i_pix.red),
        .i_green         (i_pix.green),
        .i_blue          (i_pix.blue),
        .o_sts           (sts),
        .o_nearest_index (o_res.nearest_index),
        .o_best_distance (o_res.best_distance)
    );

endmodule
